FILE: rtl/assert_macros.svh
// Assertion macros shared by the effective address RTL.
// Users must have clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define EA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("effective address same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define EA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("effective address next-cycle check failed");

`endif

FILE: rtl/ea816_pkg.sv
// Shared types, codes and helpers for the 65816 effective address block.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package ea816_pkg;

  // Item op codes
  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_READ    = 1'b1;

  // Result kinds
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_ADDR = 1'b1;

  // I/O window: addr & IO_MASK within IO_LOW..IO_HIGH is never fetched
  localparam logic [23:0] IO_MASK = 24'h40ffff;
  localparam logic [23:0] IO_LOW  = 24'h002000;
  localparam logic [23:0] IO_HIGH = 24'h005fff;

  // Addressing modes
  typedef enum logic [4:0] {
    MODE_DP       = 5'd0,
    MODE_DPX      = 5'd1,
    MODE_DPY      = 5'd2,
    MODE_IDP      = 5'd3,
    MODE_IDPX     = 5'd4,
    MODE_IDPY     = 5'd5,
    MODE_ILDP     = 5'd6,
    MODE_ILDPY    = 5'd7,
    MODE_ADDR     = 5'd8,
    MODE_ADDR_PC  = 5'd9,
    MODE_ADDRX    = 5'd10,
    MODE_ADDRY    = 5'd11,
    MODE_IADDR_PC = 5'd12,
    MODE_IADDRX   = 5'd13,
    MODE_ILADDR   = 5'd14,
    MODE_LONG     = 5'd15,
    MODE_LONGX    = 5'd16,
    MODE_SR       = 5'd17,
    MODE_ISRY     = 5'd18,
    MODE_RELB     = 5'd19,
    MODE_RELW     = 5'd20
  } ea_mode_t;

  typedef struct packed {
    logic        op;
    logic [4:0]  mode;
    logic [23:0] operand;
    logic [15:0] direct_page;
    logic [15:0] index_x;
    logic [15:0] index_y;
    logic [15:0] stack_pointer;
    logic [7:0]  data_bank;
    logic [23:0] program_counter;
    logic [7:0]  read_data;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [23:0] address;
  } out_item_t;

  // Mode decode handed from the calculator to the pointer walker
  typedef struct packed {
    logic        indirect;
    logic [15:0] base;
    logic [23:0] address;
  } calc_t;

  // Result of one item from the walker
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_t;

  function automatic logic in_io_window(input logic [23:0] a);
    logic [23:0] m;
    m = a & IO_MASK;
    return (m >= IO_LOW) && (m <= IO_HIGH);
  endfunction

endpackage

FILE: rtl/ea816_calc.sv
// Mode decoder and address adders for resolve items.
// Depends on ea816_pkg.
`timescale 1ns / 1ps

module ea816_calc import ea816_pkg::*; (
  input  in_item_t item,
  output calc_t    calc
);

  logic [15:0] op16;
  logic [15:0] dp_sum;
  logic [15:0] dpx_sum;
  logic [15:0] dpy_sum;
  logic [15:0] sr_sum;
  logic [15:0] absx_low;
  logic [15:0] pc_plus2;
  logic [15:0] pc_plus3;
  logic [23:0] db_base;
  logic [23:0] pc_bank;

  // Shared sums
  always_comb begin
    op16     = item.operand[15:0];
    dp_sum   = item.direct_page + op16;
    dpx_sum  = item.direct_page + item.index_x + op16;
    dpy_sum  = item.direct_page + item.index_y + op16;
    sr_sum   = item.stack_pointer + {8'h00, item.operand[7:0]};
    absx_low = op16 + item.index_x;
    pc_plus2 = item.program_counter[15:0] + 16'd2;
    pc_plus3 = item.program_counter[15:0] + 16'd3;
    db_base  = {item.data_bank, op16};
    pc_bank  = {item.program_counter[23:16], 16'h0000};
  end

  // Select the address, or the pointer base for indirect modes
  always_comb begin
    calc = '0;
    unique case (item.mode)
      MODE_DP:                   calc.address = {8'h00, dp_sum};
      MODE_DPX:                  calc.address = {8'h00, dpx_sum};
      MODE_DPY:                  calc.address = {8'h00, dpy_sum};
      MODE_IDP, MODE_IDPY,
      MODE_ILDP, MODE_ILDPY: begin
        calc.indirect = 1'b1;
        calc.base     = dp_sum;
      end
      MODE_IDPX: begin
        calc.indirect = 1'b1;
        calc.base     = dpx_sum;
      end
      MODE_ISRY: begin
        calc.indirect = 1'b1;
        calc.base     = sr_sum;
      end
      MODE_ADDR:                 calc.address = db_base;
      MODE_ADDR_PC, MODE_IADDR_PC: calc.address = {item.program_counter[23:16], op16};
      MODE_ADDRX:                calc.address = db_base + {8'h00, item.index_x};
      MODE_ADDRY:                calc.address = db_base + {8'h00, item.index_y};
      MODE_IADDRX:               calc.address = {item.program_counter[23:16], absx_low};
      MODE_ILADDR, MODE_LONG:    calc.address = item.operand;
      MODE_LONGX:                calc.address = item.operand + {8'h00, item.index_x};
      MODE_SR:                   calc.address = {8'h00, sr_sum};
      MODE_RELB: calc.address = pc_bank + {8'h00, pc_plus2}
                                + {{16{item.operand[7]}}, item.operand[7:0]};
      MODE_RELW: calc.address = pc_bank + {8'h00, pc_plus3}
                                + {{8{item.operand[15]}}, op16};
      default:                   calc.address = '0;
    endcase
  end

endmodule

FILE: rtl/ea816_walk.sv
// Pointer fetch sequencer: holds the indirect state, skips I/O window bytes,
// issues read requests and forms the final address. Depends on ea816_pkg.
`timescale 1ns / 1ps

module ea816_walk import ea816_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  in_item_t item,
  input  calc_t    calc,
  output res_t     res
);

  logic        busy_r, busy_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [4:0]  mode_r;
  logic [15:0] base_r;
  logic [23:0] ptr_r;
  logic [15:0] y_r;
  logic [7:0]  bank_r;

  logic        start, byte_in, immediate;
  logic [4:0]  e_mode;
  logic [15:0] e_base;
  logic [23:0] e_ptr;
  logic [15:0] e_y;
  logic [7:0]  e_bank;
  logic [1:0]  e_idx;
  logic [23:0] merged;
  logic        len3;
  logic [23:0] byte_addr [3];
  logic [2:0]  take;
  logic        found;
  logic [1:0]  sel;
  logic [23:0] bank_p16;
  logic [23:0] final_addr;

  // Classify the item against the current state
  always_comb begin
    start     = fire && (item.op == OP_RESOLVE) && !busy_r && calc.indirect;
    immediate = fire && (item.op == OP_RESOLVE) && !busy_r && !calc.indirect;
    byte_in   = fire && (item.op == OP_READ) && busy_r;
  end

  // Merge the returned byte into the pointer
  always_comb begin
    unique case (idx_r)
      2'd0:    merged = ptr_r | {16'h0000, item.read_data};
      2'd1:    merged = ptr_r | {8'h00, item.read_data, 8'h00};
      2'd2:    merged = ptr_r | {item.read_data, 16'h0000};
      default: merged = ptr_r;
    endcase
  end

  // Effective state: fresh on a resolve, advanced on a returned byte
  always_comb begin
    e_mode = start ? item.mode : mode_r;
    e_base = start ? calc.base : base_r;
    e_bank = start ? item.data_bank : bank_r;
    e_y    = start ? item.index_y : y_r;
    e_ptr  = start ? 24'h000000 : merged;
    e_idx  = start ? 2'd0 : idx_r + 2'd1;
    len3   = (e_mode == MODE_ILDP) || (e_mode == MODE_ILDPY);
  end

  // Find the next pointer byte outside the I/O window
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      byte_addr[k] = {8'h00, e_base} + 24'(k);
      take[k]      = (2'(k) >= e_idx) && ((k != 2) || len3)
                     && !in_io_window(byte_addr[k]);
    end
    found = |take;
    priority if (take[0]) sel = 2'd0;
    else if (take[1])     sel = 2'd1;
    else                  sel = 2'd2;
  end

  // Final address once the pointer is complete
  always_comb begin
    bank_p16 = {e_bank, e_ptr[15:0]};
    unique case (e_mode)
      MODE_IDP, MODE_IDPX:  final_addr = bank_p16;
      MODE_IDPY, MODE_ISRY: final_addr = bank_p16 + {8'h00, e_y};
      MODE_ILDP:            final_addr = e_ptr;
      MODE_ILDPY:           final_addr = e_ptr + {8'h00, e_y};
      default:              final_addr = '0;
    endcase
  end

  // Result selection
  always_comb begin
    res.valid = immediate || start || byte_in;
    if (immediate) begin
      res.item.kind    = KIND_ADDR;
      res.item.address = calc.address;
    end else if (found) begin
      res.item.kind    = KIND_READ;
      res.item.address = byte_addr[sel];
    end else begin
      res.item.kind    = KIND_ADDR;
      res.item.address = final_addr;
    end
  end

  // Next walk state
  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (start || byte_in) begin
      busy_nxt = found;
      idx_nxt  = found ? sel : 2'd0;
    end
  end

  // Hold or advance the walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      mode_r <= '0;
      base_r <= '0;
      ptr_r  <= '0;
      y_r    <= '0;
      bank_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      if (start || byte_in) begin
        mode_r <= e_mode;
        base_r <= e_base;
        ptr_r  <= e_ptr;
        y_r    <= e_y;
        bank_r <= e_bank;
      end
    end
  end

endmodule

FILE: rtl/cpu65816_effective_address.sv
// 65816 effective address resolver, top level.
// Channels: in_valid/in_ready/in_item carry resolve items (op = 0: mode,
//   operand and CPU registers) and read-data items (op = 1: read_data).
//   out_valid/out_ready/out_item carry results: kind 1 is a final
//   effective address, kind 0 a request to read one pointer byte.
// Indirect modes are answered by a read request; the caller returns the
//   byte as a read-data item, repeated until a final address comes out.
//   Pointer bytes in the I/O window are skipped and read as zero.
//   Resolve items while a fetch is open, and read-data items while idle,
//   are dropped without a result.
// Path: an accepted item waits in the input register until the output
//   register is free, then its result lands there; decode/adder/select sits between.
// Throughput: one item per cycle while out_ready holds, set by the single decode stage.
// Reset (rst_n low, synchronous): both registers empty, no fetch open.
// Receiver stall: the output register holds its item; the input register
//   then fills and in_ready drops until out_ready returns.
// Depends on ea816_pkg, ea816_calc, ea816_walk, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpu65816_effective_address import ea816_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      fire;
  calc_t     calc;
  res_t      res;

  // Stage handshake: the item leaves the input register when the result slot is free
  always_comb begin
    fire          = s1_valid_r && (!out_valid_r || out_ready);
    in_ready      = !s1_valid_r || fire;
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = fire ? res.valid : (out_valid_r && !out_ready);
  end

  ea816_calc u_calc (
    .item (s1_item_r),
    .calc (calc)
  );

  ea816_walk u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .calc  (calc),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (fire && res.valid) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A stalled input side means the input register is full
  `EA_ASSERT_SAME(a_stall_full, !in_ready, s1_valid_r)
  // A produced result shows up in the output register next cycle
  `EA_ASSERT_NEXT(a_result_lands, fire && res.valid, out_valid_r)
  // Read requests never target the I/O window
  `EA_ASSERT_SAME(a_no_io_read, out_valid_r && (out_item_r.kind == KIND_READ),
                  !in_io_window(out_item_r.address))

endmodule
